>>> src/pfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page free list allocator.
// Depends on nothing; every other file imports it.
package pfl_pkg;

    localparam int PAGE_W    = 12;
    localparam int SPAN_W    = 13;
    localparam int MAX_PAGES = 4096;

    localparam logic [PAGE_W-1:0] COUNT_MAX  = 12'hFFF;
    localparam logic [SPAN_W-1:0] EXT_RESET  = 13'd16;
    localparam logic              MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_INVALID = 2'd2
    } pfl_status_t;

    typedef struct packed {
        logic              mode;
        logic [PAGE_W-1:0] page_number;
    } pfl_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] granted_page;
        pfl_status_t       status;
        logic [PAGE_W-1:0] free_pages;
        logic [SPAN_W-1:0] used_span;
    } pfl_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic do_free;
        logic do_pop;
        logic do_full;
        logic grow_start;
        logic grow_step;
    } pfl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic head_zero;
        logic grow_ok;
        logic grow_last;
        logic out_free;
    } pfl_sts_t;

endpackage

>>> src/page_free_list_allocator.sv
`timescale 1ns / 1ps
// Free request, or allocate with a non-empty list: the request register captures it,
// the exec state writes the result register, waiting while the output is stalled;
// no new request is taken till then. Allocate on an empty list first runs the growth
// walk, which writes one link-store entry per cycle through its single write port.
// Reset clears the list (head 0, no free pages, span 1) and sets extend_pages to 16.
module page_free_list_allocator
    import pfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pfl_req_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output pfl_rsp_t          out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SPAN_W-1:0] cfg_data
);

    pfl_cmd_t cmd;
    pfl_sts_t sts;

    assign cfg_ready = 1'b1;

    pfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> src/pfl_datapath.sv
`timescale 1ns / 1ps
// Datapath of the page allocator: link store, list registers, growth walk
// and the result register. Depends on pfl_pkg.
module pfl_datapath
    import pfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pfl_cmd_t            cmd,
    output pfl_sts_t            sts,
    input  pfl_req_t            in_data,
    input  logic                cfg_we,
    input  logic [SPAN_W-1:0]   cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pfl_rsp_t            out_data
);

    logic [PAGE_W-1:0] link_mem [MAX_PAGES];
    logic [PAGE_W-1:0] rd_data_reg;

    pfl_req_t          req_reg,       req_next;
    logic [SPAN_W-1:0] ext_reg;
    logic [PAGE_W-1:0] head_reg,      head_next;
    logic [PAGE_W-1:0] free_reg,      free_next;
    logic [SPAN_W-1:0] span_reg,      span_next;
    logic [PAGE_W-1:0] idx_reg,       idx_next;
    logic [SPAN_W-1:0] end_reg,       end_next;
    logic              out_valid_reg, out_valid_next;
    pfl_rsp_t          out_data_reg,  out_data_next;

    logic              mem_we;
    logic [PAGE_W-1:0] mem_waddr;
    logic [PAGE_W-1:0] mem_wdata;

    logic [SPAN_W:0]   new_span;
    logic [SPAN_W-1:0] idx_inc;
    logic [SPAN_W:0]   grow_sum;
    logic [PAGE_W-1:0] free_grow;
    logic [PAGE_W:0]   inc_sum;
    logic [PAGE_W-1:0] free_inc;
    logic              page_ok;

    assign new_span  = {1'b0, span_reg} + {1'b0, ext_reg};
    assign idx_inc   = {1'b0, idx_reg} + 13'd1;
    assign grow_sum  = {2'b00, free_reg} + {1'b0, ext_reg};
    assign free_grow = (grow_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : grow_sum[PAGE_W-1:0];
    assign inc_sum   = {1'b0, free_reg} + 13'd1;
    assign free_inc  = inc_sum[PAGE_W] ? COUNT_MAX : inc_sum[PAGE_W-1:0];
    assign page_ok   = (req_reg.page_number != '0)
                    && ({1'b0, req_reg.page_number} < span_reg);

    assign sts.is_free   = (req_reg.mode == MODE_FREE);
    assign sts.head_zero = (head_reg == '0);
    assign sts.grow_ok   = (ext_reg != '0) && (new_span <= (SPAN_W+1)'(MAX_PAGES));
    assign sts.grow_last = (idx_inc == end_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        req_next       = req_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        span_next      = span_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = idx_inc[PAGE_W-1:0];

        if (cmd.load_req)
        begin
            req_next = in_data;
        end

        if (cmd.grow_start)
        begin
            idx_next = span_reg[PAGE_W-1:0];
            end_next = new_span[SPAN_W-1:0];
        end

        // New pages are chained upward; the last one points at the old
        // head, which is always zero when growth runs.
        if (cmd.grow_step)
        begin
            mem_we   = 1'b1;
            idx_next = idx_inc[PAGE_W-1:0];
            if (sts.grow_last)
            begin
                mem_wdata = '0;
                head_next = span_reg[PAGE_W-1:0];
                span_next = end_reg;
                free_next = free_grow;
            end
        end

        if (cmd.do_free)
        begin
            out_data_next.granted_page = '0;
            if (page_ok)
            begin
                mem_we    = 1'b1;
                mem_waddr = req_reg.page_number;
                mem_wdata = head_reg;
                head_next = req_reg.page_number;
                free_next = free_inc;
                out_data_next.status = STATUS_OK;
            end
            else
            begin
                out_data_next.status = STATUS_INVALID;
            end
        end

        if (cmd.do_pop)
        begin
            head_next = rd_data_reg;
            free_next = (free_reg == '0) ? '0 : free_reg - 12'd1;
            out_data_next.granted_page = head_reg;
            out_data_next.status       = STATUS_OK;
        end

        if (cmd.do_full)
        begin
            out_data_next.granted_page = '0;
            out_data_next.status       = STATUS_FULL;
        end

        if (cmd.do_free || cmd.do_pop || cmd.do_full)
        begin
            out_valid_next           = 1'b1;
            out_data_next.free_pages = free_next;
            out_data_next.used_span  = span_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg       <= EXT_RESET;
            head_reg      <= '0;
            free_reg      <= '0;
            span_reg      <= 13'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ext_reg <= cfg_data;
            end
            head_reg      <= head_next;
            free_reg      <= free_next;
            span_reg      <= span_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        end_reg      <= end_next;
        out_data_reg <= out_data_next;
    end

    // The link of the current head is read every cycle into a register, so it is
    // ready in the cycle after the head settles.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[head_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_grow_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grow_step |-> head_reg == '0)
        else $error("growth step with a non-empty free list");

    a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |-> head_reg != '0)
        else $error("pop of the reserved page");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pop |=> out_valid_reg && out_data_reg.status == STATUS_OK
                       && out_data_reg.granted_page != '0)
        else $error("pop did not produce a granted page");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        span_reg != '0 && span_reg <= SPAN_W'(MAX_PAGES))
        else $error("page span out of range");

endmodule

>>> src/pfl_ctrl.sv
`timescale 1ns / 1ps
// Controller of the page allocator: sequences request capture, growth walk
// and commit. Depends on pfl_pkg.
module pfl_ctrl
    import pfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pfl_sts_t sts,
    output pfl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GROW,
        ST_SETTLE
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_free)
                begin
                    if (sts.out_free)
                    begin
                        cmd.do_free = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (!sts.head_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.do_pop = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.grow_ok)
                begin
                    cmd.grow_start = 1'b1;
                    state_next     = ST_GROW;
                end
                else if (sts.out_free)
                begin
                    cmd.do_full = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_GROW:
            begin
                cmd.grow_step = 1'b1;
                if (sts.grow_last)
                begin
                    state_next = ST_SETTLE;
                end
            end
            // Settle state, for the link of the new head to be read back.
            ST_SETTLE:
            begin
                state_next = ST_EXEC;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_req, cmd.do_free, cmd.do_pop, cmd.do_full,
                  cmd.grow_start, cmd.grow_step}))
        else $error("more than one command issued");

    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (state_reg != ST_IDLE))
        else $error("input stall disagrees with controller state");

endmodule

>>> test/page_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_free_list_allocator: random and directed
// allocate/free traffic against an in-bench model of the free list.
// Depends on pfl_pkg and the allocator RTL only.
module page_free_list_allocator_tb;
    import pfl_pkg::*;

    localparam logic MODE_ALLOC = ~MODE_FREE;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    pfl_req_t          in_data;
    logic              out_valid;
    logic              out_stall;
    pfl_rsp_t          out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SPAN_W-1:0] cfg_data;

    // Shadow copy of the allocator state.
    logic [PAGE_W-1:0] link_mem [0:MAX_PAGES-1];
    bit                held_map [0:MAX_PAGES-1];
    logic [PAGE_W-1:0] list_head;
    logic [PAGE_W-1:0] free_count;
    logic [SPAN_W-1:0] page_span;
    logic [SPAN_W-1:0] extend_pages;

    pfl_req_t request_queue [$];
    pfl_rsp_t pending_answers [$];
    pfl_rsp_t answer_due;
    bit       slot_open;
    int       tx_idle_pct;
    int       rx_idle_pct;
    int       hold_left;
    int       error_count;
    int       request_total;
    int       beat_total;

    page_free_list_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [PAGE_W-1:0] saturating_add(logic [PAGE_W-1:0] cnt, int n);
        int sum;
        sum = int'(cnt) + n;
        return (sum > int'(COUNT_MAX)) ? COUNT_MAX : PAGE_W'(sum);
    endfunction

    function automatic pfl_rsp_t serve_request(pfl_req_t req);
        pfl_rsp_t rsp;
        int       grown_span;
        int       pg;
        rsp = '0;
        rsp.status = STATUS_OK;
        if (req.mode == MODE_ALLOC)
        begin
            // An empty list is refilled in ascending order before the pop.
            if (list_head == '0)
            begin
                grown_span = int'(page_span) + int'(extend_pages);
                if (extend_pages == '0 || grown_span > MAX_PAGES)
                begin
                    rsp.status = STATUS_FULL;
                end
                else
                begin
                    for (pg = int'(page_span); pg < grown_span; pg++)
                    begin
                        link_mem[pg] = (pg + 1 < grown_span) ? PAGE_W'(pg + 1) : list_head;
                    end
                    list_head  = page_span[PAGE_W-1:0];
                    free_count = saturating_add(free_count, int'(extend_pages));
                    page_span  = SPAN_W'(grown_span);
                end
            end
            if (rsp.status == STATUS_OK)
            begin
                rsp.granted_page   = list_head;
                held_map[list_head] = 1'b1;
                list_head = link_mem[list_head];
                if (free_count != '0)
                begin
                    free_count = free_count - 1'b1;
                end
            end
        end
        else if (req.page_number != '0 && SPAN_W'(req.page_number) < page_span)
        begin
            link_mem[req.page_number] = list_head;
            held_map[req.page_number] = 1'b0;
            list_head  = req.page_number;
            free_count = saturating_add(free_count, 1);
        end
        else
        begin
            rsp.status = STATUS_INVALID;
        end
        rsp.free_pages = free_count;
        rsp.used_span  = page_span;
        return rsp;
    endfunction

    // Sender: a new beat is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            slot_open = !in_valid;
            if (in_valid && !in_stall)
            begin
                pending_answers.push_back(serve_request(in_data));
                request_total++;
                slot_open = 1'b1;
            end
            if (slot_open)
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with an optional long hold-off counted down here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beat_total++;
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no request outstanding");
                error_count++;
            end
            else
            begin
                answer_due = pending_answers.pop_front();
                check_field("granted_page", answer_due.granted_page, out_data.granted_page);
                check_field("status", answer_due.status, out_data.status);
                check_field("free_pages", answer_due.free_pages, out_data.free_pages);
                check_field("used_span", answer_due.used_span, out_data.used_span);
            end
        end
    end

    task automatic add_request(logic mode, int page);
        pfl_req_t req;
        req.mode        = mode;
        req.page_number = PAGE_W'(page);
        request_queue.push_back(req);
    endtask

    task automatic wait_drained();
        while (request_queue.size() > 0 || in_valid || pending_answers.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_extend(int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= SPAN_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        extend_pages = SPAN_W'(value);
        cfg_valid <= 1'b0;
    endtask

    // Pops every page on the list so that the next allocate has to grow.
    task automatic empty_list();
        int n;
        for (n = int'(free_count); n > 0; n--)
        begin
            add_request(MODE_ALLOC, $urandom_range(MAX_PAGES - 1));
        end
        wait_drained();
    endtask

    function automatic int bad_page();
        if (int'(page_span) >= MAX_PAGES || $urandom_range(3) == 0)
        begin
            return 0;
        end
        return $urandom_range(MAX_PAGES - 1, int'(page_span));
    endfunction

    // Frees held pages, or pages out of range when queued (page 0 or past the span).
    task automatic queue_random_chunk(int n);
        int unsigned spare [$];
        int          k;
        int          r;
        int          idx;
        for (k = 1; k < MAX_PAGES; k++)
        begin
            if (held_map[k])
            begin
                spare.push_back(k);
            end
        end
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                add_request(MODE_FREE, bad_page());
            end
            else if (r < 45 && spare.size() > 0)
            begin
                idx = $urandom_range(spare.size() - 1);
                add_request(MODE_FREE, spare[idx]);
                spare.delete(idx);
            end
            else
            begin
                add_request(MODE_ALLOC, $urandom_range(MAX_PAGES - 1));
            end
        end
    endtask

    function automatic int pick_extend();
        int r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            return MAX_PAGES;
        end
        if (r == 1)
        begin
            return 1;
        end
        return $urandom_range(64, 2);
    endfunction

    initial
    begin
        int phase;
        int chunk;
        int pg;
        int n_back;
        int first_back;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        hold_left   = 0;
        error_count = 0;
        request_total = 0;
        beat_total  = 0;
        for (pg = 0; pg < MAX_PAGES; pg++)
        begin
            link_mem[pg] = '0;
            held_map[pg] = 1'b0;
        end
        list_head    = '0;
        free_count   = '0;
        page_span    = SPAN_W'(1);
        extend_pages = EXT_RESET;
        tx_idle_pct  = 33;
        rx_idle_pct  = 65;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: invalid frees on the bare space, growth with the reset size, the upper
        // bound of a free, then zero growth, growth past the limit and growth by one page.
        add_request(MODE_FREE, 0);
        add_request(MODE_FREE, MAX_PAGES - 1);
        add_request(MODE_FREE, 1);
        add_request(MODE_ALLOC, MAX_PAGES - 1);
        add_request(MODE_ALLOC, 0);
        add_request(MODE_FREE, 1);
        add_request(MODE_FREE, 17);
        add_request(MODE_FREE, 2);
        add_request(MODE_ALLOC, 0);
        wait_drained();
        empty_list();
        write_extend(0);
        add_request(MODE_ALLOC, 0);
        wait_drained();
        write_extend(MAX_PAGES);
        add_request(MODE_ALLOC, 0);
        wait_drained();
        write_extend(1);
        add_request(MODE_ALLOC, 0);
        add_request(MODE_ALLOC, 0);
        wait_drained();

        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 33 : 0;
            for (chunk = 0; chunk < 10; chunk++)
            begin
                if (chunk % 3 == 0)
                begin
                    write_extend(pick_extend());
                end
                if (phase == 2 && chunk == 1)
                begin
                    // Output held off while input keeps coming: the block must back up.
                    @(posedge clk);
                    hold_left <= 400;
                end
                queue_random_chunk(26);
                wait_drained();
            end
        end

        // Fill the page space: first one page too many, then an exact fit.
        empty_list();
        write_extend(MAX_PAGES - int'(page_span) + 1);
        add_request(MODE_ALLOC, 0);
        wait_drained();
        write_extend(MAX_PAGES - int'(page_span));
        add_request(MODE_ALLOC, 0);
        wait_drained();

        // Return a few held pages and then the first of them once more. The list
        // now loops through that page, so the allocates that follow never run dry.
        n_back     = 0;
        first_back = 0;
        for (pg = 1; pg < MAX_PAGES && n_back < 4; pg++)
        begin
            if (held_map[pg])
            begin
                if (n_back == 0)
                begin
                    first_back = pg;
                end
                add_request(MODE_FREE, pg);
                n_back++;
            end
        end
        if (n_back > 0)
        begin
            add_request(MODE_FREE, first_back);
        end
        for (pg = 0; pg < 12; pg++)
        begin
            add_request(MODE_ALLOC, $urandom_range(MAX_PAGES - 1));
        end
        wait_drained();

        $display("Ran %0d allocate/free requests and checked %0d result beats.",
                 request_total, beat_total);
        $display("Page space grew to %0d pages, with full, invalid and repeated-free cases.",
                 page_span);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
